/* rtl/scm_pkg.sv */
`timescale 1ns / 1ps
package scm_pkg;

    localparam int VALUE_BITS = 43;
    localparam int IDX_BITS   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int ASSETS_W   = 4;
    localparam int OBS_W      = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ASSETS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_OBS    = 2'd1;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_START,
        ST_MAC,
        ST_DRAIN,
        ST_DIVS,
        ST_DIVW,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic st_wr;
        logic sum_add;
        logic sum_wr;
        logic sum_clr;
        logic sum_rd;
        logic mac_rd;
        logic acc_clr;
        logic div_start;
        logic emit;
    } cmd_t;

endpackage

/* rtl/scm_div.sv */
`timescale 1ns / 1ps
module scm_div
    import scm_pkg::*;
#(
    parameter int NW   = 59,
    parameter int DENW = 18
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [NW-1:0]   num,
    input  logic [DENW-1:0] den,
    output logic            done,
    output logic [NW-1:0]   quo
);

    localparam int CNTW = (NW > 1) ? $clog2(NW) : 1;

    logic            run_reg, run_next;
    logic            done_reg, done_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [DENW-1:0] rem_reg, rem_next;
    logic [NW-1:0]   q_reg, q_next;
    logic [DENW:0]   shifted;
    logic            fits;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        shifted   = {rem_reg, q_reg[NW-1]};
        fits      = (shifted >= {1'b0, den});
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            rem_next = '0;
            q_next   = num;
        end
        else if (run_reg)
        begin
            rem_next = fits ? DENW'(shifted - {1'b0, den}) : DENW'(shifted);
            q_next   = {q_reg[NW-2:0], fits};
            if (cnt_reg == CNTW'(NW - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule

/* rtl/scm_dp.sv */
`timescale 1ns / 1ps
module scm_dp
    import scm_pkg::*;
#(
    parameter int MAX_ASSETS  = 8,
    parameter int MAX_OBS     = 256,
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 8
)
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  cmd_t                                      cmd,
    input  logic signed [SAMPLE_BITS-1:0]             sample,
    input  logic [$clog2(MAX_ASSETS*MAX_OBS)-1:0]     waddr,
    input  logic [$clog2(MAX_ASSETS*MAX_OBS)-1:0]     raddr_a,
    input  logic [$clog2(MAX_ASSETS*MAX_OBS)-1:0]     raddr_b,
    input  logic [((MAX_ASSETS > 1) ? $clog2(MAX_ASSETS) : 1)-1:0] sum_waddr,
    input  logic [((MAX_ASSETS > 1) ? $clog2(MAX_ASSETS) : 1)-1:0] sum_raddr_a,
    input  logic [((MAX_ASSETS > 1) ? $clog2(MAX_ASSETS) : 1)-1:0] sum_raddr_b,
    input  logic [$clog2(MAX_OBS+1)-1:0]              n_eff,
    output logic                                      div_done,
    output logic signed [VALUE_BITS-1:0]              value
);

    localparam int S     = SAMPLE_BITS;
    localparam int NB    = $clog2(MAX_OBS + 1);
    localparam int DEPTH = MAX_ASSETS * MAX_OBS;
    localparam int SUMW  = S + NB;
    localparam int NPW   = 2 * S + NB + 1;
    localparam int DW    = 2 * S + 2 * NB + 1;
    localparam int NW    = DW + FRAC_BITS;
    localparam int DENW  = 2 * NB;
    localparam int CW    = ((NW > VALUE_BITS) ? NW : VALUE_BITS) + 1;

    logic signed [S-1:0]      smem [DEPTH];
    logic signed [SUMW-1:0]   sumem [MAX_ASSETS];

    logic signed [S-1:0]      ra_reg, rb_reg;
    logic signed [SUMW-1:0]   sa_reg, sb_reg;
    logic signed [2*S-1:0]    prod_reg;
    logic signed [NPW-1:0]    np_reg;
    logic signed [2*SUMW-1:0] sij_reg;
    logic signed [DW-1:0]     acc_reg, acc_next;
    logic signed [SUMW-1:0]   run_reg, run_next;
    logic [DENW-1:0]          den_reg;
    logic                     v1_reg, v2_reg, v3_reg;
    logic                     neg_reg;
    logic signed [VALUE_BITS-1:0] value_reg;

    logic signed [DW-1:0]     diff;
    logic [DW-1:0]            mag;
    logic [NW-1:0]            num;
    logic [NW-1:0]            quo;
    logic [CW-1:0]            qx, vmax, sres;
    logic signed [VALUE_BITS-1:0] sat;

    always_ff @(posedge clk)
    begin
        if (cmd.st_wr)
            smem[waddr] <= sample;
        if (cmd.mac_rd)
        begin
            ra_reg <= smem[raddr_a];
            rb_reg <= smem[raddr_b];
        end
        if (cmd.sum_wr)
            sumem[sum_waddr] <= run_reg + SUMW'(sample);
        if (cmd.sum_rd)
        begin
            sa_reg <= sumem[sum_raddr_a];
            sb_reg <= sumem[sum_raddr_b];
        end
        prod_reg <= ra_reg * rb_reg;
        np_reg   <= prod_reg * $signed({1'b0, n_eff});
        sij_reg  <= sa_reg * sb_reg;
        den_reg  <= DENW'(n_eff) * DENW'(n_eff - 1'b1);
        if (cmd.div_start)
            neg_reg <= diff[DW-1];
        if (cmd.emit)
            value_reg <= sat;
    end

    always_comb
    begin
        run_next = run_reg;
        if (cmd.sum_clr || cmd.sum_wr)
            run_next = '0;
        else if (cmd.sum_add)
            run_next = run_reg + SUMW'(sample);
        acc_next = acc_reg;
        if (cmd.acc_clr)
            acc_next = '0;
        else if (v3_reg)
            acc_next = acc_reg + DW'(np_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= '0;
            acc_reg <= '0;
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
        end
        else
        begin
            run_reg <= run_next;
            acc_reg <= acc_next;
            v1_reg  <= cmd.mac_rd;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
        end
    end

    // N*Sxy - Sx*Sy, divided as a magnitude
    assign diff = acc_reg - DW'(sij_reg);
    assign mag  = diff[DW-1] ? DW'(-diff) : DW'(diff);
    assign num  = NW'(mag) << FRAC_BITS;

    scm_div #(
        .NW   (NW),
        .DENW (DENW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (num),
        .den   (den_reg),
        .done  (div_done),
        .quo   (quo)
    );

    always_comb
    begin
        qx   = CW'(quo);
        vmax = (CW'(1) << (VALUE_BITS - 1)) - CW'(1);
        if (!neg_reg)
            sres = (qx > vmax) ? vmax : qx;
        else
            sres = (qx > vmax + CW'(1)) ? CW'(-(vmax + CW'(1))) : CW'(-qx);
        sat = sres[VALUE_BITS-1:0];
    end

    assign value = value_reg;

endmodule

/* rtl/scm_ctrl.sv */
`timescale 1ns / 1ps
module scm_ctrl
    import scm_pkg::*;
#(
    parameter int MAX_ASSETS = 8,
    parameter int MAX_OBS    = 256
)
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      start,
    output logic                                      busy,
    input  logic                                      cfg_valid,
    output logic                                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]                      cfg_index,
    input  logic [CFG_DATA_W-1:0]                     cfg_data,
    input  logic                                      div_done,
    output cmd_t                                      cmd,
    output logic [$clog2(MAX_ASSETS*MAX_OBS)-1:0]     waddr,
    output logic [$clog2(MAX_ASSETS*MAX_OBS)-1:0]     raddr_a,
    output logic [$clog2(MAX_ASSETS*MAX_OBS)-1:0]     raddr_b,
    output logic [((MAX_ASSETS > 1) ? $clog2(MAX_ASSETS) : 1)-1:0] sum_waddr,
    output logic [((MAX_ASSETS > 1) ? $clog2(MAX_ASSETS) : 1)-1:0] sum_raddr_a,
    output logic [((MAX_ASSETS > 1) ? $clog2(MAX_ASSETS) : 1)-1:0] sum_raddr_b,
    output logic [$clog2(MAX_OBS+1)-1:0]              n_eff,
    output logic                                      strobe,
    output logic [IDX_BITS-1:0]                       row,
    output logic [IDX_BITS-1:0]                       col,
    output logic                                      last
);

    localparam int NB  = $clog2(MAX_OBS + 1);
    localparam int AW  = $clog2(MAX_ASSETS * MAX_OBS);
    localparam int AIW = (MAX_ASSETS > 1) ? $clog2(MAX_ASSETS) : 1;

    state_t          state_reg, state_next;
    logic            busy_reg, busy_next;
    logic [ASSETS_W-1:0] num_assets_reg;
    logic [OBS_W-1:0]    num_obs_reg;
    logic [NB-1:0]   obs_reg, obs_next;
    logic [AIW-1:0]  asset_reg, asset_next;
    logic [AW-1:0]   laddr_reg, laddr_next;
    logic [AIW-1:0]  i_reg, i_next, j_reg, j_next;
    logic [AW-1:0]   ibase_reg, ibase_next, jbase_reg, jbase_next;
    logic [NB-1:0]   k_reg, k_next;
    logic [1:0]      drain_reg, drain_next;
    logic            strobe_reg, strobe_next;
    logic [IDX_BITS-1:0] row_reg, row_next, col_reg, col_next;
    logic            last_reg, last_next;

    logic            cfg_wr, accept, entry_last;
    logic [AIW-1:0]  m_last;
    logic [NB-1:0]   n_last;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign accept    = start && !busy_reg;

    // out-of-range register values are clamped
    always_comb
    begin
        if (num_assets_reg == '0)
            m_last = '0;
        else if (32'(num_assets_reg) > MAX_ASSETS)
            m_last = AIW'(MAX_ASSETS - 1);
        else
            m_last = AIW'(num_assets_reg - 1'b1);
        if (num_obs_reg < OBS_W'(2))
            n_eff = NB'(2);
        else if (32'(num_obs_reg) > MAX_OBS)
            n_eff = NB'(MAX_OBS);
        else
            n_eff = NB'(num_obs_reg);
        n_last = n_eff - 1'b1;
    end

    assign entry_last = (i_reg == m_last) && (j_reg == m_last);

    always_comb
    begin
        state_next  = state_reg;
        busy_next   = busy_reg;
        obs_next    = obs_reg;
        asset_next  = asset_reg;
        laddr_next  = laddr_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        ibase_next  = ibase_reg;
        jbase_next  = jbase_reg;
        k_next      = k_reg;
        drain_next  = drain_reg;
        strobe_next = 1'b0;
        row_next    = row_reg;
        col_next    = col_reg;
        last_next   = last_reg;
        cmd         = '0;
        case (state_reg)
            ST_LOAD:
            begin
                if (cfg_wr)
                begin
                    obs_next    = '0;
                    asset_next  = '0;
                    laddr_next  = '0;
                    cmd.sum_clr = 1'b1;
                end
                else if (accept)
                begin
                    cmd.st_wr  = 1'b1;
                    laddr_next = laddr_reg + 1'b1;
                    if (obs_reg == n_last)
                    begin
                        cmd.sum_wr = 1'b1;
                        obs_next   = '0;
                        if (asset_reg == m_last)
                        begin
                            asset_next = '0;
                            laddr_next = '0;
                            busy_next  = 1'b1;
                            i_next     = '0;
                            j_next     = '0;
                            ibase_next = '0;
                            jbase_next = '0;
                            state_next = ST_START;
                        end
                        else
                        begin
                            asset_next = asset_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        obs_next    = obs_reg + 1'b1;
                        cmd.sum_add = 1'b1;
                    end
                end
            end
            ST_START:
            begin
                cmd.acc_clr = 1'b1;
                cmd.sum_rd  = 1'b1;
                k_next      = '0;
                state_next  = ST_MAC;
            end
            ST_MAC:
            begin
                cmd.mac_rd = 1'b1;
                if (k_reg == n_last)
                begin
                    drain_next = '0;
                    state_next = ST_DRAIN;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                // read, product, scale, accumulate
                if (drain_reg == 2'd2)
                    state_next = ST_DIVS;
                else
                    drain_next = drain_reg + 1'b1;
            end
            ST_DIVS:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIVW;
            end
            ST_DIVW:
            begin
                if (div_done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                cmd.emit    = 1'b1;
                strobe_next = 1'b1;
                row_next    = IDX_BITS'(i_reg);
                col_next    = IDX_BITS'(j_reg);
                last_next   = entry_last;
                state_next  = ST_START;
                if (j_reg == m_last)
                begin
                    j_next     = '0;
                    jbase_next = '0;
                    if (i_reg == m_last)
                    begin
                        busy_next  = 1'b0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        ibase_next = ibase_reg + AW'(n_eff);
                    end
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    jbase_next = jbase_reg + AW'(n_eff);
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            busy_reg       <= 1'b0;
            num_assets_reg <= ASSETS_W'(8);
            num_obs_reg    <= OBS_W'(256);
            obs_reg        <= '0;
            asset_reg      <= '0;
            laddr_reg      <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            ibase_reg      <= '0;
            jbase_reg      <= '0;
            k_reg          <= '0;
            drain_reg      <= '0;
            strobe_reg     <= 1'b0;
            row_reg        <= '0;
            col_reg        <= '0;
            last_reg       <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            busy_reg   <= busy_next;
            if (cfg_wr && cfg_index == CFG_NUM_ASSETS)
                num_assets_reg <= cfg_data[ASSETS_W-1:0];
            if (cfg_wr && cfg_index == CFG_NUM_OBS)
                num_obs_reg <= cfg_data[OBS_W-1:0];
            obs_reg    <= obs_next;
            asset_reg  <= asset_next;
            laddr_reg  <= laddr_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            ibase_reg  <= ibase_next;
            jbase_reg  <= jbase_next;
            k_reg      <= k_next;
            drain_reg  <= drain_next;
            strobe_reg <= strobe_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
            last_reg   <= last_next;
        end
    end

    assign busy        = busy_reg;
    assign waddr       = laddr_reg;
    assign raddr_a     = ibase_reg + AW'(k_reg);
    assign raddr_b     = jbase_reg + AW'(k_reg);
    assign sum_waddr   = asset_reg;
    assign sum_raddr_a = i_reg;
    assign sum_raddr_b = j_reg;
    assign strobe      = strobe_reg;
    assign row         = row_reg;
    assign col         = col_reg;
    assign last        = last_reg;

endmodule

/* rtl/sample_covariance_matrix_unit.sv */
`timescale 1ns / 1ps
// Sample covariance matrix unit.
// Samples go in on start/sample, one word per cycle while busy is low, in
// row-major order: num_obs observations of asset 0, then asset 1, and so on.
// The word that completes num_assets * num_obs samples raises busy on the
// next cycle. The unit then emits the num_assets^2 matrix entries row by row
// on row/col/value/last, each valid for the single cycle that strobe is high;
// last marks the final entry. The receiver cannot stall the output.
// Each entry streams one store read per cycle through the multiply-accumulate
// pipe, then a restoring divider makes one quotient bit a cycle of an
// NW-bit quotient, NW = 2*SAMPLE_BITS + 2*clog2(MAX_OBS+1) + 1 + FRAC_BITS
// (59 at the defaults). busy drops with the last entry's strobe. Registers
// num_assets (index 0) and num_obs (index 1) are written on the cfg channel;
// the user must write only while busy is low (not enforced); a write restarts
// a partial load. Reset sets num_assets = 8, num_obs = 256, empties the load.
module sample_covariance_matrix_unit
    import scm_pkg::*;
#(
    parameter int MAX_ASSETS  = 8,
    parameter int MAX_OBS     = 256,
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 8
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    output logic                          strobe,
    output logic [IDX_BITS-1:0]           row,
    output logic [IDX_BITS-1:0]           col,
    output logic signed [VALUE_BITS-1:0]  value,
    output logic                          last
);

    localparam int NB  = $clog2(MAX_OBS + 1);
    localparam int AW  = $clog2(MAX_ASSETS * MAX_OBS);
    localparam int AIW = (MAX_ASSETS > 1) ? $clog2(MAX_ASSETS) : 1;

    cmd_t            cmd;
    logic            div_done;
    logic [AW-1:0]   waddr, raddr_a, raddr_b;
    logic [AIW-1:0]  sum_waddr, sum_raddr_a, sum_raddr_b;
    logic [NB-1:0]   n_eff;

    scm_ctrl #(
        .MAX_ASSETS (MAX_ASSETS),
        .MAX_OBS    (MAX_OBS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .div_done    (div_done),
        .cmd         (cmd),
        .waddr       (waddr),
        .raddr_a     (raddr_a),
        .raddr_b     (raddr_b),
        .sum_waddr   (sum_waddr),
        .sum_raddr_a (sum_raddr_a),
        .sum_raddr_b (sum_raddr_b),
        .n_eff       (n_eff),
        .strobe      (strobe),
        .row         (row),
        .col         (col),
        .last        (last)
    );

    scm_dp #(
        .MAX_ASSETS  (MAX_ASSETS),
        .MAX_OBS     (MAX_OBS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sample      (sample),
        .waddr       (waddr),
        .raddr_a     (raddr_a),
        .raddr_b     (raddr_b),
        .sum_waddr   (sum_waddr),
        .sum_raddr_a (sum_raddr_a),
        .sum_raddr_b (sum_raddr_b),
        .n_eff       (n_eff),
        .div_done    (div_done),
        .value       (value)
    );

endmodule
